[sv/hrbp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hrbp_pkg;

  typedef logic [7:0] byte_t;

  localparam int LINE_BYTES_DEF = 50;
  localparam int TAIL_BYTES     = 4;
  localparam int MAX_TOKEN      = 27;
  localparam int TOK_W          = $clog2(MAX_TOKEN + 1);
  localparam int AUTH_LEN       = 21;
  localparam int CLEN_LEN       = 15;
  localparam int CFG_AW         = 4;

  localparam byte_t CH_SP  = 8'h20;
  localparam byte_t CH_TAB = 8'h09;
  localparam byte_t CH_LF  = 8'h0A;
  localparam byte_t CH_VT  = 8'h0B;
  localparam byte_t CH_FF  = 8'h0C;
  localparam byte_t CH_CR  = 8'h0D;
  localparam byte_t CH_PLS = 8'h2B;
  localparam byte_t CH_MIN = 8'h2D;
  localparam byte_t CH_0   = 8'h30;
  localparam byte_t CH_9   = 8'h39;

  localparam logic [7:0] METHOD_LIMIT_RST = 8'd8;
  localparam logic [7:0] PATH_LIMIT_RST   = 8'd32;
  localparam logic [7:0] BODY_LIMIT_RST   = 8'd64;
  localparam logic signed [15:0] DECL_RST = 16'sd10;

  // register indexes on the config port
  localparam logic [1:0] REG_METHOD_LIMIT = 2'd0;
  localparam logic [1:0] REG_PATH_LIMIT   = 2'd1;
  localparam logic [1:0] REG_BODY_LIMIT   = 2'd2;

  localparam logic [1:0] PH_METHOD = 2'd0;
  localparam logic [1:0] PH_PATH   = 2'd1;
  localparam logic [1:0] PH_HDR    = 2'd2;

  localparam byte_t AUTH_KEY [AUTH_LEN] = '{
    "A", "u", "t", "h", "o", "r", "i", "z", "a", "t", "i", "o", "n", ":", " ",
    "B", "a", "s", "i", "c", " "};
  localparam byte_t CLEN_KEY [CLEN_LEN] = '{
    "C", "o", "n", "t", "e", "n", "t", "-", "L", "e", "n", "g", "t", "h", ":"};

  typedef enum logic [2:0] {
    KIND_NONE, KIND_METHOD, KIND_PATH, KIND_BODY, KIND_TOKEN, KIND_DONE
  } kind_t;

  typedef struct packed {
    logic take_byte;
    logic step_final;
    logic load_buf;
    logic shift_buf;
    logic skip_auth;
    logic skip_clen;
    logic cl_sign;
    logic cl_digit;
    logic cl_commit;
    logic emit_tok;
  } cmd_t;

  typedef struct packed {
    logic line_end;
    logic b0_zero;
    logic b0_ws;
    logic b0_sign;
    logic b0_digit;
    logic auth_hit;
    logic clen_hit;
    logic tok_full;
    logic out_free;
  } sts_t;

  function automatic logic is_ws(input byte_t c);
    return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF || c == CH_CR;
  endfunction

endpackage
`default_nettype wire

[sv/hrbp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module hrbp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire hrbp_pkg::sts_t sts,
  output hrbp_pkg::cmd_t     cmd
);
  import hrbp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_STEP, S_CL_SRCH, S_CL_WS, S_CL_SGN, S_CL_DIG,
    S_RELOAD, S_AU_SRCH, S_AU_WS, S_AU_TOK, S_FINAL
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.take_byte = in_valid;
        if (in_valid) state_nxt = S_STEP;
      end
      S_STEP: begin
        if (sts.line_end) begin
          cmd.load_buf = 1'b1;
          state_nxt    = S_CL_SRCH;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_CL_SRCH: begin
        if (sts.b0_zero) begin
          state_nxt = S_RELOAD;
        end else if (sts.clen_hit) begin
          cmd.skip_clen = 1'b1;
          state_nxt     = S_CL_WS;
        end else begin
          cmd.shift_buf = 1'b1;
        end
      end
      S_CL_WS: begin
        if (sts.b0_ws) cmd.shift_buf = 1'b1;
        else state_nxt = S_CL_SGN;
      end
      S_CL_SGN: begin
        if (sts.b0_sign) begin
          cmd.cl_sign   = 1'b1;
          cmd.shift_buf = 1'b1;
        end
        state_nxt = S_CL_DIG;
      end
      S_CL_DIG: begin
        if (sts.b0_digit) begin
          cmd.cl_digit  = 1'b1;
          cmd.shift_buf = 1'b1;
        end else begin
          cmd.cl_commit = 1'b1;
          state_nxt     = S_RELOAD;
        end
      end
      S_RELOAD: begin
        cmd.load_buf = 1'b1;
        state_nxt    = S_AU_SRCH;
      end
      S_AU_SRCH: begin
        if (sts.b0_zero) begin
          state_nxt = S_FINAL;
        end else if (sts.auth_hit) begin
          cmd.skip_auth = 1'b1;
          state_nxt     = S_AU_WS;
        end else begin
          cmd.shift_buf = 1'b1;
        end
      end
      S_AU_WS: begin
        if (sts.b0_ws) cmd.shift_buf = 1'b1;
        else state_nxt = S_AU_TOK;
      end
      S_AU_TOK: begin
        if (sts.b0_zero || sts.b0_ws || sts.tok_full) begin
          state_nxt = S_FINAL;
        end else if (sts.out_free) begin
          cmd.emit_tok  = 1'b1;
          cmd.shift_buf = 1'b1;
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.step_final = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire

[sv/hrbp_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module hrbp_dp #(
  parameter int LINE_BYTES = hrbp_pkg::LINE_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hrbp_pkg::cmd_t     cmd,
  output hrbp_pkg::sts_t          sts,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic [7:0]         method_limit,
  input  wire logic [7:0]         path_limit,
  input  wire logic [7:0]         body_limit,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_kind,
  output logic [7:0]              out_position,
  output logic [7:0]              out_byte_value,
  output logic signed [15:0]      out_body_length,
  output logic                    out_last
);
  import hrbp_pkg::*;

  localparam int WIN_N = LINE_BYTES - 1;
  localparam int BUF_N = LINE_BYTES - 2;

  byte_t              d_r;
  byte_t              win_r [WIN_N];
  byte_t              buf_r [BUF_N];
  byte_t              bd_r  [TAIL_BYTES];
  logic [1:0]         phase_r;
  logic               finished_r;
  logic [7:0]         mc_r, pc_r, bc_r;
  logic signed [15:0] decl_r;
  logic               neg_r, dig_r;
  logic [15:0]        mag_r;
  logic [TOK_W-1:0]   tok_cnt_r;

  logic               out_valid_r, out_last_r;
  kind_t              out_kind_r;
  logic [7:0]         out_pos_r, out_byte_r;
  logic signed [15:0] out_len_r;

  byte_t       b0;
  logic        auth_hit, clen_hit, blank, body_ok, active, out_free;
  logic        tok_last, fin_quiet;
  logic [3:0]  dig4;
  logic [18:0] mag_wide;
  logic [15:0] mag_sat;
  kind_t       fin_kind;
  logic [7:0]  fin_pos, fin_byte;

  assign b0       = buf_r[0];
  assign out_free = !out_valid_r || !out_stall;
  assign active   = !finished_r && (phase_r == PH_HDR);

  // key compare at the head of the scan buffer
  always_comb begin
    auth_hit = 1'b1;
    for (int j = 0; j < AUTH_LEN; j++) if (buf_r[j] != AUTH_KEY[j]) auth_hit = 1'b0;
    clen_hit = 1'b1;
    for (int j = 0; j < CLEN_LEN; j++) if (buf_r[j] != CLEN_KEY[j]) clen_hit = 1'b0;
  end

  assign dig4     = 4'(b0 - CH_0);
  assign mag_wide = ({3'b0, mag_r} << 3) + ({3'b0, mag_r} << 1) + {15'b0, dig4};
  assign mag_sat  = (mag_wide > 19'd40000) ? 16'd40000 : mag_wide[15:0];

  always_comb begin
    sts.line_end = active && (win_r[WIN_N-1] == CH_CR) && (d_r == CH_LF);
    sts.b0_zero  = (b0 == 8'h00);
    sts.b0_ws    = is_ws(b0);
    sts.b0_sign  = (b0 == CH_PLS) || (b0 == CH_MIN);
    sts.b0_digit = (b0 >= CH_0) && (b0 <= CH_9);
    sts.auth_hit = auth_hit;
    sts.clen_hit = clen_hit;
    sts.tok_full = (tok_cnt_r == TOK_W'(MAX_TOKEN));
    sts.out_free = out_free;
  end

  assign blank   = (bd_r[0] == CH_CR) && (bd_r[1] == CH_LF) &&
                   (bd_r[2] == CH_CR) && (bd_r[3] == CH_LF);
  assign body_ok = (bc_r < body_limit) && ($signed({8'b0, bc_r}) < decl_r);

  // single result that closes a request byte, unless token bytes stand in for an empty one
  always_comb begin
    fin_kind = KIND_NONE;
    fin_pos  = 8'd0;
    fin_byte = 8'd0;
    if (finished_r || phase_r > PH_HDR) begin
      fin_kind = KIND_NONE;
    end else if (phase_r == PH_METHOD) begin
      if (d_r != CH_SP && mc_r < method_limit) begin
        fin_kind = KIND_METHOD;
        fin_pos  = mc_r;
        fin_byte = d_r;
      end
    end else if (phase_r == PH_PATH) begin
      if (d_r != CH_SP && pc_r < path_limit) begin
        fin_kind = KIND_PATH;
        fin_pos  = pc_r;
        fin_byte = d_r;
      end
    end else if (blank) begin
      if (body_ok) begin
        fin_kind = KIND_BODY;
        fin_pos  = bc_r;
        fin_byte = d_r;
      end else begin
        fin_kind = KIND_DONE;
      end
    end
  end

  // token bytes stand in for the empty closing result
  assign tok_last  = (fin_kind == KIND_NONE) &&
                     ((buf_r[1] == 8'h00) || is_ws(buf_r[1]) ||
                      (tok_cnt_r == TOK_W'(MAX_TOKEN - 1)));
  assign fin_quiet = (tok_cnt_r != '0) && (fin_kind == KIND_NONE);

  always_ff @(posedge clk) begin
    if (cmd.take_byte) d_r <= in_data_byte;
  end

  // scan buffer: loads from the window, shifts toward entry 0, fills with nul
  for (genvar i = 0; i < BUF_N; i++) begin : g_buf
    byte_t nxt1, nxta, nxtc;
    if (i + 1 < BUF_N) begin : g_s1
      assign nxt1 = buf_r[i+1];
    end else begin : g_z1
      assign nxt1 = 8'h00;
    end
    if (i + AUTH_LEN < BUF_N) begin : g_sa
      assign nxta = buf_r[i+AUTH_LEN];
    end else begin : g_za
      assign nxta = 8'h00;
    end
    if (i + CLEN_LEN < BUF_N) begin : g_sc
      assign nxtc = buf_r[i+CLEN_LEN];
    end else begin : g_zc
      assign nxtc = 8'h00;
    end
    always_ff @(posedge clk) begin
      if (cmd.load_buf) buf_r[i] <= win_r[i];
      else if (cmd.skip_auth) buf_r[i] <= nxta;
      else if (cmd.skip_clen) buf_r[i] <= nxtc;
      else if (cmd.shift_buf) buf_r[i] <= nxt1;
    end
  end

  // content length parse and token count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r     <= 1'b0;
      dig_r     <= 1'b0;
      mag_r     <= '0;
      tok_cnt_r <= '0;
    end else begin
      if (cmd.load_buf || cmd.take_byte) begin
        neg_r     <= 1'b0;
        dig_r     <= 1'b0;
        mag_r     <= '0;
        tok_cnt_r <= '0;
      end else begin
        if (cmd.cl_sign) neg_r <= (b0 == CH_MIN);
        if (cmd.cl_digit) begin
          mag_r <= mag_sat;
          dig_r <= 1'b1;
        end
        if (cmd.emit_tok) tok_cnt_r <= tok_cnt_r + 1'b1;
      end
    end
  end

  // parser state, updated once per byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_METHOD;
      finished_r <= 1'b0;
      mc_r       <= '0;
      pc_r       <= '0;
      bc_r       <= '0;
      decl_r     <= DECL_RST;
      for (int i = 0; i < WIN_N; i++) win_r[i] <= CH_SP;
      for (int i = 0; i < TAIL_BYTES; i++) bd_r[i] <= 8'h00;
    end else begin
      if (cmd.cl_commit && dig_r) begin
        if (neg_r) decl_r <= (mag_r > 16'd32768) ? -16'sd32768 : -$signed(mag_r);
        else decl_r <= (mag_r > 16'd32767) ? 16'sd32767 : $signed(mag_r);
      end
      if (cmd.step_final && !finished_r) begin
        if (phase_r == PH_METHOD) begin
          if (d_r == CH_SP) phase_r <= PH_PATH;
          else if (mc_r < method_limit) mc_r <= mc_r + 8'd1;
        end else if (phase_r == PH_PATH) begin
          if (d_r == CH_SP) phase_r <= PH_HDR;
          else if (pc_r < path_limit) pc_r <= pc_r + 8'd1;
        end else if (phase_r == PH_HDR) begin
          if (sts.line_end) begin
            for (int i = 0; i < WIN_N; i++) win_r[i] <= CH_SP;
          end else begin
            for (int i = 0; i < WIN_N - 1; i++) win_r[i] <= win_r[i+1];
            win_r[WIN_N-1] <= d_r;
          end
          if (blank) begin
            if (body_ok) bc_r <= bc_r + 8'd1;
            else finished_r <= 1'b1;
          end else begin
            for (int i = 0; i < TAIL_BYTES - 1; i++) bd_r[i] <= bd_r[i+1];
            bd_r[TAIL_BYTES-1] <= d_r;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_tok || (cmd.step_final && !fin_quiet)) begin
      out_valid_r <= 1'b1;
    end else if (out_free) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_tok) begin
      out_kind_r <= KIND_TOKEN;
      out_pos_r  <= 8'(tok_cnt_r);
      out_byte_r <= b0;
      out_len_r  <= decl_r;
      out_last_r <= tok_last;
    end else if (cmd.step_final && !fin_quiet) begin
      out_kind_r <= fin_kind;
      out_pos_r  <= fin_pos;
      out_byte_r <= fin_byte;
      out_len_r  <= decl_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_position    = out_pos_r;
  assign out_byte_value  = out_byte_r;
  assign out_body_length = out_len_r;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire

[sv/http_request_byte_parser_core.sv]
// an accepted byte passes the step and final states, then its result is registered
// at a CR LF the sequencer also scans the line for Content-Length and Authorization, one token byte per step
// one byte in flight: in_stall stays high until the scan sequencer returns to idle
// reset: synchronous active-low rst_n; limits return to 8, 32, 64, length to ten
// line window resets to spaces, no clearing pass needed
`timescale 1ns / 1ps
`default_nettype none
module http_request_byte_parser_core #(
  parameter int LINE_BYTES = hrbp_pkg::LINE_BYTES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // request byte stream
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [7:0]               in_data_byte,
  // results
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [2:0]                    out_kind,
  output logic [7:0]                    out_position,
  output logic [7:0]                    out_byte_value,
  output logic signed [15:0]            out_body_length,
  output logic                          out_last,
  // register port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [hrbp_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import hrbp_pkg::*;

  logic [7:0] method_limit_r, path_limit_r, body_limit_r;
  logic [1:0] reg_idx;
  logic       wr_en;
  cmd_t       cmd;
  sts_t       sts;

  // registers sit on word boundaries, low address bits ignored
  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_limit_r <= METHOD_LIMIT_RST;
      path_limit_r   <= PATH_LIMIT_RST;
      body_limit_r   <= BODY_LIMIT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_METHOD_LIMIT: method_limit_r <= pwdata[7:0];
        REG_PATH_LIMIT:   path_limit_r   <= pwdata[7:0];
        REG_BODY_LIMIT:   body_limit_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back, unused index reads zero
  always_comb begin
    case (reg_idx)
      REG_METHOD_LIMIT: prdata = {24'b0, method_limit_r};
      REG_PATH_LIMIT:   prdata = {24'b0, path_limit_r};
      REG_BODY_LIMIT:   prdata = {24'b0, body_limit_r};
      default:          prdata = 32'b0;
    endcase
  end

  // sequencer: one byte in flight, walks the line scan
  hrbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // window, scan buffer, counters and result register
  hrbp_dp #(
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_data_byte    (in_data_byte),
    .method_limit    (method_limit_r),
    .path_limit      (path_limit_r),
    .body_limit      (body_limit_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_position    (out_position),
    .out_byte_value  (out_byte_value),
    .out_body_length (out_body_length),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire
